>>> hdl/plsh_pkg.sv
// shared types, constants and helpers for the phong light shading pipeline
// no dependencies
package plsh_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned DOT_W         = 34;
  localparam int unsigned OUT_W         = 17;
  localparam logic [OUT_W-1:0] BRIGHT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_AMBIENT = 2'd0,
    MODE_POINT   = 2'd1,
    MODE_DIR     = 2'd2,
    MODE_SPHERE  = 2'd3
  } mode_e;

  function automatic logic signed [31:0] smul16(logic signed [15:0] a, logic signed [15:0] b);
    return a * b;
  endfunction

endpackage

>>> hdl/phong_light_shading.sv
// phong light shading top level: front end, power chain, final scale and saturation
// depends on plsh_pkg, plsh_front, plsh_pow
// 14 register stages, from the front end input registers to brightness_o
// throughput one item per cycle while the output is not stalled, all stages advance together
// a stall at the output freezes every stage; nothing is dropped or repeated
// reset clears the valid bits only, payload registers are not reset
module phong_light_shading #(
  parameter int unsigned FRAC_BITS = plsh_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] intensity_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic signed [15:0] light_x_i,
  input  logic signed [15:0] light_y_i,
  input  logic signed [15:0] light_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] brightness_o
);

  localparam int unsigned NST = 14;
  localparam int unsigned DW  = plsh_pkg::DOT_W;
  localparam int unsigned DDW = DW - FRAC_BITS;
  localparam int unsigned SW  = (51 > 16 + 2 * FRAC_BITS) ? (51 - 2 * FRAC_BITS) : 16;
  localparam int unsigned LW  = SW + 20;
  localparam int unsigned TW  = (50 > 1 + 2 * FRAC_BITS) ? (50 - 2 * FRAC_BITS) : 1;
  localparam int unsigned AW  = FRAC_BITS + 1;
  localparam int unsigned SBW = 2 + 16 + 1 + DDW + TW + DDW;
  localparam int unsigned SMW = ((DDW > AW) ? DDW : AW) + 1;
  localparam int unsigned PRW = 16 + SMW;
  localparam int unsigned SPW = TW + DDW + plsh_pkg::OUT_W;

  logic                  en;
  logic [NST-1:0]        vld_q;
  logic signed [15:0]    n [3];
  logic signed [15:0]    v [3];
  logic signed [15:0]    l [3];
  logic [1:0]            f_mode;
  logic [15:0]           f_inten;
  logic                  f_zero;
  logic [DDW-1:0]        f_d, f_k2s;
  logic [TW-1:0]         f_t;
  logic signed [LW-1:0]  f_rl;
  logic [SBW-1:0]        sb_in, sb_out;
  logic [AW-1:0]         p;
  logic [1:0]            p_mode;
  logic [15:0]           p_inten;
  logic                  p_zero;
  logic [DDW-1:0]        p_d, p_k2s;
  logic [TW-1:0]         p_t;
  logic [1:0]            f13_mode_q;
  logic [15:0]           f13_inten_q;
  logic                  f13_zero_q;
  logic [PRW-1:0]        prod_q;
  logic [SPW-1:0]        sph_q;
  logic [PRW-1:0]        prod_sh;
  logic [SPW-1:0]        sph_sh;
  logic [16:0]           res_d;

  assign en          = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NST-1];

  assign n = '{normal_x_i, normal_y_i, normal_z_i};
  assign v = '{view_x_i, view_y_i, view_z_i};
  assign l = '{light_x_i, light_y_i, light_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  plsh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .mode_i  (mode_i),
    .inten_i (intensity_i),
    .n_i     (n),
    .v_i     (v),
    .l_i     (l),
    .mode_o  (f_mode),
    .inten_o (f_inten),
    .zero_o  (f_zero),
    .d_o     (f_d),
    .t_o     (f_t),
    .k2s_o   (f_k2s),
    .rl_o    (f_rl)
  );

  assign sb_in = {f_mode, f_inten, f_zero, f_d, f_t, f_k2s};

  plsh_pow #(.FRAC_BITS(FRAC_BITS), .LW(LW), .SBW(SBW)) u_pow (
    .clk_i (clk_i),
    .en_i  (en),
    .rl_i  (f_rl),
    .sb_i  (sb_in),
    .p_o   (p),
    .sb_o  (sb_out)
  );

  assign {p_mode, p_inten, p_zero, p_d, p_t, p_k2s} = sb_out;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f13_mode_q  <= p_mode;
      f13_inten_q <= p_inten;
      f13_zero_q  <= p_zero;
      prod_q      <= PRW'(p_inten) * (PRW'(p_d) + PRW'(p));
      sph_q       <= SPW'(p_t) * SPW'(p_k2s);
    end
  end

  always_comb begin
    prod_sh = prod_q >> FRAC_BITS;
    sph_sh  = sph_q >> FRAC_BITS;
    if (f13_mode_q == plsh_pkg::MODE_AMBIENT) begin
      res_d = 17'(f13_inten_q);
    end else if (f13_zero_q) begin
      res_d = '0;
    end else if (f13_mode_q == plsh_pkg::MODE_SPHERE) begin
      res_d = (sph_sh > SPW'(plsh_pkg::BRIGHT_MAX)) ? plsh_pkg::BRIGHT_MAX : 17'(sph_sh);
    end else begin
      res_d = (prod_sh > PRW'(plsh_pkg::BRIGHT_MAX)) ? plsh_pkg::BRIGHT_MAX : 17'(prod_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      brightness_o <= res_d;
    end
  end

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item missing from first stage");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_ambient_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-2] && en && f13_mode_q == plsh_pkg::MODE_AMBIENT)
      |=> (brightness_o == 17'($past(f13_inten_q))))
    else $error("ambient item altered");

endmodule

>>> hdl/plsh_front.sv
// dot products, reflection vector and specular cosine (four stages)
// depends on plsh_pkg
module plsh_front #(
  parameter int unsigned FRAC_BITS = plsh_pkg::FRAC_BITS_DEF,
  localparam int unsigned DW  = plsh_pkg::DOT_W,
  localparam int unsigned VNW = DW - FRAC_BITS,
  localparam int unsigned PW  = VNW + 17,
  localparam int unsigned SW  = (51 > 16 + 2 * FRAC_BITS) ? (51 - 2 * FRAC_BITS) : 16,
  localparam int unsigned RW  = SW + 1,
  localparam int unsigned LW  = RW + 19,
  localparam int unsigned DDW = DW - FRAC_BITS,
  localparam int unsigned TW  = (50 > 1 + 2 * FRAC_BITS) ? (50 - 2 * FRAC_BITS) : 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [1:0]            mode_i,
  input  logic [15:0]           inten_i,
  input  logic signed [15:0]    n_i [3],
  input  logic signed [15:0]    v_i [3],
  input  logic signed [15:0]    l_i [3],
  output logic [1:0]            mode_o,
  output logic [15:0]           inten_o,
  output logic                  zero_o,
  output logic [DDW-1:0]        d_o,
  output logic [TW-1:0]         t_o,
  output logic [DDW-1:0]        k2s_o,
  output logic signed [LW-1:0]  rl_o
);

  // stage 1
  logic [1:0]              s1_mode_q;
  logic [15:0]             s1_inten_q;
  logic signed [15:0]      s1_n_q [3];
  logic signed [15:0]      s1_v_q [3];
  logic signed [15:0]      s1_l_q [3];
  logic signed [DW-1:0]    s1_nl_q, s1_vn_q, s1_k1_q;
  // stage 2
  logic [1:0]              s2_mode_q;
  logic [15:0]             s2_inten_q;
  logic signed [15:0]      s2_v_q [3];
  logic signed [16:0]      s2_l_q [3];
  logic signed [PW-1:0]    s2_pr_q [3];
  logic                    s2_zero_q;
  logic [DDW-1:0]          s2_d_q, s2_k1s_q, s2_k2s_q;
  // stage 3
  logic [1:0]              s3_mode_q;
  logic [15:0]             s3_inten_q;
  logic signed [16:0]      s3_l_q [3];
  logic signed [RW-1:0]    s3_r_q [3];
  logic                    s3_zero_q;
  logic [DDW-1:0]          s3_d_q, s3_k2s_q;
  logic [DDW+15:0]         s3_tf_q;

  logic signed [VNW-1:0]   vn;
  logic signed [PW-1:0]    pr [3];
  logic signed [DW-1:0]    draw;
  logic                    zero_d;
  logic signed [PW:0]      rf [3];
  logic signed [RW+16:0]   rp [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mode_q  <= mode_i;
      s1_inten_q <= inten_i;
      s1_n_q     <= n_i;
      s1_v_q     <= v_i;
      s1_l_q     <= l_i;
      s1_nl_q <= DW'(plsh_pkg::smul16(n_i[0], l_i[0])) + DW'(plsh_pkg::smul16(n_i[1], l_i[1]))
               + DW'(plsh_pkg::smul16(n_i[2], l_i[2]));
      s1_vn_q <= DW'(plsh_pkg::smul16(v_i[0], n_i[0])) + DW'(plsh_pkg::smul16(v_i[1], n_i[1]))
               + DW'(plsh_pkg::smul16(v_i[2], n_i[2]));
      s1_k1_q <= DW'(plsh_pkg::smul16(l_i[0], v_i[0])) + DW'(plsh_pkg::smul16(l_i[1], v_i[1]))
               + DW'(plsh_pkg::smul16(l_i[2], v_i[2]));
    end
  end

  always_comb begin
    vn = VNW'(s1_vn_q >>> FRAC_BITS);
    for (int k = 0; k < 3; k++) begin
      pr[k] = PW'(vn) * PW'(s1_n_q[k]);
    end
    draw = (s1_mode_q == plsh_pkg::MODE_DIR) ? -s1_nl_q : s1_nl_q;
    case (s1_mode_q)
      plsh_pkg::MODE_POINT:  zero_d = s1_nl_q < 0;
      plsh_pkg::MODE_DIR:    zero_d = s1_nl_q >= 0;
      plsh_pkg::MODE_SPHERE: zero_d = (s1_nl_q < 0) || (s1_k1_q < 0);
      default:               zero_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_mode_q  <= s1_mode_q;
      s2_inten_q <= s1_inten_q;
      s2_v_q     <= s1_v_q;
      for (int k = 0; k < 3; k++) begin
        s2_l_q[k]  <= (s1_mode_q == plsh_pkg::MODE_DIR) ? -17'(s1_l_q[k]) : 17'(s1_l_q[k]);
        s2_pr_q[k] <= pr[k] <<< 1;
      end
      s2_zero_q <= zero_d;
      s2_d_q    <= DDW'(draw >>> FRAC_BITS);
      s2_k1s_q  <= DDW'(s1_k1_q >>> FRAC_BITS);
      s2_k2s_q  <= DDW'(s1_nl_q >>> FRAC_BITS);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rf[k] = (PW+1)'(s2_v_q[k]) - (PW+1)'(s2_pr_q[k] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_mode_q  <= s2_mode_q;
      s3_inten_q <= s2_inten_q;
      s3_l_q     <= s2_l_q;
      for (int k = 0; k < 3; k++) begin
        s3_r_q[k] <= RW'(rf[k]);
      end
      s3_zero_q <= s2_zero_q;
      s3_d_q    <= s2_d_q;
      s3_k2s_q  <= s2_k2s_q;
      s3_tf_q   <= (DDW+16)'(s2_inten_q) * (DDW+16)'(s2_k1s_q);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rp[k] = (RW+17)'(s3_r_q[k]) * (RW+17)'(s3_l_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_o  <= s3_mode_q;
      inten_o <= s3_inten_q;
      zero_o  <= s3_zero_q;
      d_o     <= s3_d_q;
      k2s_o   <= s3_k2s_q;
      t_o     <= TW'(s3_tf_q >> FRAC_BITS);
      rl_o    <= LW'(rp[0]) + LW'(rp[1]) + LW'(rp[2]);
    end
  end

endmodule

>>> hdl/plsh_pow.sv
// specular power 50 by a chain of registered squarings (eight stages)
// depends on plsh_pkg
module plsh_pow #(
  parameter int unsigned FRAC_BITS = plsh_pkg::FRAC_BITS_DEF,
  parameter int unsigned LW        = 40,
  parameter int unsigned SBW       = 1,
  localparam int unsigned AW       = FRAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [LW-1:0] rl_i,
  input  logic [SBW-1:0]       sb_i,
  output logic [AW-1:0]        p_o,
  output logic [SBW-1:0]       sb_o
);

  localparam logic [AW-1:0] One = AW'(1) << FRAC_BITS;

  logic [AW-1:0]  x_q   [8];
  logic [AW-1:0]  a2c_q [2:6];
  logic [AW-1:0]  a16_q;
  logic [SBW-1:0] sb_q  [8];
  logic [LW-1:0]  mag, a0;
  logic [AW-1:0]  a;

  function automatic logic [AW-1:0] fmul(logic [AW-1:0] x, logic [AW-1:0] y);
    logic [2*AW-1:0] p;
    p = (2*AW)'(x) * (2*AW)'(y);
    return AW'(p >> FRAC_BITS);
  endfunction

  always_comb begin
    mag = (rl_i < 0) ? LW'(-rl_i) : LW'(rl_i);
    a0  = mag >> FRAC_BITS;
    a   = (a0 > LW'(One)) ? One : AW'(a0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= a;
      sb_q[0] <= sb_i;
      for (int i = 1; i < 8; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        x_q[i] <= fmul(x_q[i-1], x_q[i-1]);
      end
      a2c_q[2] <= x_q[1];
      for (int i = 3; i < 7; i++) begin
        a2c_q[i] <= a2c_q[i-1];
      end
      a16_q  <= x_q[4];
      x_q[6] <= fmul(x_q[5], a16_q);
      x_q[7] <= fmul(x_q[6], a2c_q[6]);
    end
  end

  assign p_o  = x_q[7];
  assign sb_o = sb_q[7];

endmodule

>>> test/tb_phong_light_shading.sv
// self-checking testbench for phong_light_shading: random and directed shading items
// depends on plsh_pkg and the phong_light_shading rtl
`timescale 1ns / 1ps

class shade_scoreboard;
  logic [16:0] pending_q[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  static function longint sx(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  static function longint fshift(longint x);
    return x >>> 14;
  endfunction

  static function longint pow50(longint raw);
    longint mag;
    longint a;
    longint a2;
    longint a4;
    longint a8;
    longint a16;
    longint a32;
    mag = raw < 0 ? -raw : raw;
    a = mag >> 14;
    if (a > 16384) a = 16384;
    a2 = (a * a) >> 14;
    a4 = (a2 * a2) >> 14;
    a8 = (a4 * a4) >> 14;
    a16 = (a8 * a8) >> 14;
    a32 = (a16 * a16) >> 14;
    return ((((a32 * a16) >> 14) * a2) >> 14);
  endfunction

  static function logic [16:0] shade(plsh_pkg::mode_e md, logic [15:0] inten,
                                     logic [15:0] nv[3], logic [15:0] vv[3],
                                     logic [15:0] lv[3]);
    longint n[3];
    longint v[3];
    longint l[3];
    longint r[3];
    longint k1;
    longint k2;
    longint t;
    longint res;
    longint vn;
    longint rl;
    for (int i = 0; i < 3; i++) begin
      n[i] = sx(nv[i]);
      v[i] = sx(vv[i]);
      l[i] = sx(lv[i]);
    end
    if (md == plsh_pkg::MODE_AMBIENT) return 17'(inten);
    if (md == plsh_pkg::MODE_SPHERE) begin
      k1 = l[0] * v[0] + l[1] * v[1] + l[2] * v[2];
      k2 = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      if (k1 < 0 || k2 < 0) return '0;
      t = (longint'(inten) * (k1 >> 14)) >> 14;
      res = (t * (k2 >> 14)) >> 14;
    end else begin
      if (md == plsh_pkg::MODE_DIR)
        for (int i = 0; i < 3; i++) l[i] = -l[i];
      k2 = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      if (k2 < 0 || (md == plsh_pkg::MODE_DIR && k2 == 0)) return '0;
      vn = fshift(v[0] * n[0] + v[1] * n[1] + v[2] * n[2]);
      for (int i = 0; i < 3; i++) r[i] = v[i] - fshift(2 * vn * n[i]);
      rl = r[0] * l[0] + r[1] * l[1] + r[2] * l[2];
      res = (longint'(inten) * ((k2 >> 14) + pow50(rl))) >> 14;
    end
    return res > 131071 ? 17'h1ffff : res[16:0];
  endfunction

  function void note_item(plsh_pkg::mode_e md, logic [15:0] inten, logic [15:0] nv[3],
                          logic [15:0] vv[3], logic [15:0] lv[3]);
    pending_q = {pending_q, shade(md, inten, nv, vv, lv)};
  endfunction

  function void check_result(logic [16:0] got);
    logic [16:0] exp_b;
    if (pending_q.size() == 0) begin
      $error("brightness: unexpected result, actual %0d", got);
      errors++;
      return;
    end
    exp_b = pending_q.pop_front();
    if (got !== exp_b) begin
      $error("brightness: expected %0d, actual %0d", exp_b, got);
      errors++;
    end
  endfunction
endclass

module tb_phong_light_shading;

  localparam int N_RANDOM = 1250;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [15:0] intensity_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [15:0] view_x_i = '0, view_y_i = '0, view_z_i = '0;
  logic signed [15:0] light_x_i = '0, light_y_i = '0, light_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [16:0] brightness_o;

  shade_scoreboard sb = new();
  bit quiet_out = 1'b0;
  bit hold_out = 1'b0;
  bit drive_done = 1'b0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  phong_light_shading uut (.*);

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic send_item(logic [1:0] md, logic [15:0] inten, logic [15:0] nv[3],
                           logic [15:0] vv[3], logic [15:0] lv[3], bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    intensity_i <= inten;
    {normal_x_i, normal_y_i, normal_z_i} <= {nv[0], nv[1], nv[2]};
    {view_x_i, view_y_i, view_z_i} <= {vv[0], vv[1], vv[2]};
    {light_x_i, light_y_i, light_z_i} <= {lv[0], lv[1], lv[2]};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(plsh_pkg::mode_e'(md), inten, nv, vv, lv);
  endtask

  task automatic send_random(bit may_idle);
    logic [15:0] nv[3];
    logic [15:0] vv[3];
    logic [15:0] lv[3];
    logic [15:0] inten;
    for (int i = 0; i < 3; i++) begin
      nv[i] = rand_comp();
      vv[i] = rand_comp();
      lv[i] = rand_comp();
    end
    inten = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
    send_item(2'($urandom), inten, nv, vv, lv, may_idle);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(brightness_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (hold_out) out_stall_i <= 1'b1;
    else if (quiet_out) out_stall_i <= 1'b0;
    else out_stall_i <= $urandom_range(0, 99) < 7;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("phong_light_shading regression: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] px[3];
    logic [15:0] nx[3];
    logic [15:0] pz[3];
    logic [15:0] zz[3];
    logic [15:0] mx[3];
    logic [15:0] mn[3];
    px = '{16'sd16384, 16'd0, 16'd0};
    nx = '{-16'sd16384, 16'd0, 16'd0};
    pz = '{16'd0, 16'd0, 16'sd16384};
    zz = '{16'd0, 16'd0, 16'd0};
    mx = '{16'h7fff, 16'h7fff, 16'h7fff};
    mn = '{16'h8000, 16'h8000, 16'h8000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ambient, point, directional and spherical corner cases
    send_item(plsh_pkg::MODE_AMBIENT, 16'hffff, px, px, px, 0);
    send_item(plsh_pkg::MODE_AMBIENT, 16'h0000, mx, mx, mx, 0);
    send_item(plsh_pkg::MODE_POINT, 16'h0100, px, px, px, 0);
    send_item(plsh_pkg::MODE_POINT, 16'hffff, px, nx, px, 0);
    send_item(plsh_pkg::MODE_POINT, 16'hffff, px, px, nx, 0);
    send_item(plsh_pkg::MODE_POINT, 16'h0100, px, pz, pz, 0);
    send_item(plsh_pkg::MODE_POINT, 16'hffff, mx, mx, mx, 0);
    send_item(plsh_pkg::MODE_POINT, 16'hffff, nx, nx, nx, 0);
    send_item(plsh_pkg::MODE_DIR, 16'h0100, px, px, nx, 0);
    send_item(plsh_pkg::MODE_DIR, 16'h0100, px, px, pz, 0);
    send_item(plsh_pkg::MODE_DIR, 16'hffff, px, px, px, 0);
    send_item(plsh_pkg::MODE_DIR, 16'hffff, mx, zz, mn, 0);
    send_item(plsh_pkg::MODE_SPHERE, 16'hffff, px, px, px, 0);
    send_item(plsh_pkg::MODE_SPHERE, 16'hffff, px, nx, px, 0);
    send_item(plsh_pkg::MODE_SPHERE, 16'hffff, nx, px, px, 0);
    send_item(plsh_pkg::MODE_SPHERE, 16'hffff, mx, mx, mx, 0);
    send_item(plsh_pkg::MODE_SPHERE, 16'h0080, zz, zz, zz, 0);
    wait_drained();

    // output held off while input keeps coming
    hold_out = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_out = 1'b0;
      end
      repeat (40) send_random(0);
    join
    wait_drained();

    quiet_out = 1'b1;
    repeat (200) send_random(0);
    quiet_out = 1'b0;
    for (int i = 0; i < N_RANDOM - 240; i++) begin
      send_random(1);
      if (i == 500) wait_drained();
    end
    wait_drained();
    repeat (30) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("phong_light_shading regression: pass");
    else
      $display("phong_light_shading regression: fail");
    $finish;
  end
endmodule
